// ===== hdl/mcrc_pkg.sv =====
// Package for the Modbus CRC-16 frame checker: widths, register map,
// result record and the byte-wise reflected CRC update. No dependencies.
package mcrc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam int unsigned OutW   = 40;  // 34 payload bits padded to whole bytes

  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

  // Register word index (paddr[2])
  localparam logic RegCheckMode = 1'b0;

  localparam logic CheckModeReset = 1'b1;

  typedef struct packed {
    logic            frame_short;
    logic            crc_match;
    logic [CrcW-1:0] received_crc;
    logic [CrcW-1:0] crc_value;
  } result_t;

  // One byte through the reflected CRC, eight shift steps.
  function automatic logic [CrcW-1:0] crc_byte(logic [CrcW-1:0] crc,
                                               logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = {1'b0, c[CrcW-1:1]} ^ CrcPoly;
      end else begin
        c = {1'b0, c[CrcW-1:1]};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/modbus_crc16_frame_check.sv =====
// Modbus CRC-16 frame checker: byte stream in, one result per frame out.
// A last byte passes the input stage register, then the result register, to tvalid.
// Throughput: one byte per cycle; the input stage stalls only while a last
// byte waits for the result register, which is held by m_axis_tready.
// Reset (rst_ni, asynchronous): accumulator 0xFFFF, no bytes held, check mode on.
// Depends on mcrc_pkg and mcrc_engine.
module modbus_crc16_frame_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mcrc_pkg::ByteW-1:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic                         s_axis_tlast_i,   // last_byte
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [15:0] crc_value, [31:16] received_crc, [32] crc_match,
  // [33] frame_short, [39:34] zero
  output logic [mcrc_pkg::OutW-1:0]    m_axis_tdata_o,
  // configuration
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mcrc_pkg::PaddrW-1:0]  paddr_i,
  input  logic [mcrc_pkg::PdataW-1:0]  pwdata_i,
  output logic [mcrc_pkg::PdataW-1:0]  prdata_o,
  output logic                         pready_o
);

  localparam int unsigned ResW = $bits(mcrc_pkg::result_t);

  logic check_mode_q;

  logic                       in_valid_q;
  logic [mcrc_pkg::ByteW-1:0] in_data_q;
  logic                       in_last_q;

  logic              out_valid_q;
  mcrc_pkg::result_t out_q;

  logic              out_free;
  logic              step;
  logic              s_fire;
  mcrc_pkg::result_t result;

  // config port
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == mcrc_pkg::RegCheckMode)
                    ? {{(mcrc_pkg::PdataW-1){1'b0}}, check_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q <= mcrc_pkg::CheckModeReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[2] == mcrc_pkg::RegCheckMode) begin
      check_mode_q <= pwdata_i[0];
    end
  end

  // handshake: a byte with no result always moves on, a last byte needs room
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || step;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  mcrc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_i       (in_data_q),
    .last_i       (in_last_q),
    .check_mode_i (check_mode_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(mcrc_pkg::OutW-ResW){1'b0}}, out_q};

  // input stage only waits behind a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |-> in_last_q && out_valid_q && !m_axis_tready_i)
    else $error("input stage stalled without a blocked result");

  a_short_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_short |->
      out_q.received_crc == '0 && !out_q.crc_match)
    else $error("short frame carries a received CRC or a match");

  a_match_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.crc_match |-> out_q.crc_value == out_q.received_crc)
    else $error("match flagged on differing CRC values");

endmodule

// ===== hdl/mcrc_engine.sv =====
// Frame state and CRC update for the Modbus CRC-16 frame checker.
// Holds the accumulator and the two held-back bytes; depends on mcrc_pkg.
module mcrc_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [mcrc_pkg::ByteW-1:0]  data_i,
  input  logic                        last_i,
  input  logic                        check_mode_i,
  output mcrc_pkg::result_t           result_o
);

  logic [mcrc_pkg::CrcW-1:0]  acc_q, acc_d;
  logic [mcrc_pkg::ByteW-1:0] older_q, older_d;
  logic [mcrc_pkg::ByteW-1:0] newer_q, newer_d;
  logic [1:0]                 count_q, count_d;

  logic [mcrc_pkg::ByteW-1:0] crc_in;
  logic [mcrc_pkg::CrcW-1:0]  crc_out;
  logic                       two_held;

  assign two_held = count_q[1];
  // plain mode feeds the new byte, check mode the oldest held one
  assign crc_in   = check_mode_i ? older_q : data_i;
  assign crc_out  = mcrc_pkg::crc_byte(acc_q, crc_in);

  always_comb begin
    result_o = '0;
    if (!check_mode_i) begin
      result_o.crc_value = crc_out;
    end else if (count_q == 2'd0) begin
      result_o.crc_value   = acc_q;
      result_o.frame_short = 1'b1;
    end else begin
      result_o.crc_value    = two_held ? crc_out : acc_q;
      result_o.received_crc = {newer_q, data_i};
      result_o.crc_match    = (result_o.crc_value == {newer_q, data_i});
    end
  end

  always_comb begin
    acc_d   = acc_q;
    older_d = older_q;
    newer_d = newer_q;
    count_d = count_q;
    if (step_i) begin
      if (last_i) begin
        acc_d   = mcrc_pkg::CrcInit;
        older_d = '0;
        newer_d = '0;
        count_d = 2'd0;
      end else if (!check_mode_i) begin
        acc_d = crc_out;
      end else begin
        if (two_held) begin
          acc_d = crc_out;
        end
        older_d = newer_q;
        newer_d = data_i;
        count_d = (count_q == 2'd0) ? 2'd1 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= mcrc_pkg::CrcInit;
      older_q <= '0;
      newer_q <= '0;
      count_q <= 2'd0;
    end else begin
      acc_q   <= acc_d;
      older_q <= older_d;
      newer_q <= newer_d;
      count_q <= count_d;
    end
  end

endmodule
